[rtl/core/lnps_pkg.sv]
// Package: item types and sequencer states for the last-note-priority stack.
package lnps_pkg;

  typedef struct packed {
    logic [3:0] chan;
    logic [6:0] key_pitch;
    logic [6:0] velocity;
  } in_item_t;

  typedef struct packed {
    logic [3:0] out_chan;
    logic [6:0] out_pitch;
    logic [6:0] out_velocity;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SHIFT,
    ST_TOP,
    ST_NEXT,
    ST_SEARCH,
    ST_EMIT
  } lnps_state_e;

endpackage

[rtl/core/lnps_mem.sv]
// Held-note memory: one write port, one read port, registered read data.
module lnps_mem #(
  parameter int unsigned STACK_DEPTH = 16,
  localparam int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  lnps_pkg::in_item_t wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output lnps_pkg::in_item_t rdata_o
);
  import lnps_pkg::*;

  in_item_t mem_q [STACK_DEPTH];
  in_item_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lnps_ctrl.sv]
// Sequencer: push, pop, search and compaction of the held-note stack in memory.
module lnps_ctrl #(
  parameter int unsigned STACK_DEPTH = 16,
  localparam int unsigned AW = $clog2(STACK_DEPTH),
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lnps_pkg::in_item_t  in_item_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output lnps_pkg::out_item_t res_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output lnps_pkg::in_item_t  mem_wdata_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  lnps_pkg::in_item_t  mem_rdata_i
);
  import lnps_pkg::*;

  lnps_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  in_item_t      ev_q, ev_d;
  out_item_t     res_q, res_d;

  logic [CW-1:0] cnt_m1, cnt_m2, idx_inc;
  logic          cnt_full, cnt_zero, cnt_one, rd_match, ev_on, in_on, shift_more, search_last;

  assign cnt_m1      = cnt_q - CW'(1);
  assign cnt_m2      = cnt_q - CW'(2);
  assign idx_inc     = CW'(idx_q) + CW'(1);
  assign cnt_full    = cnt_q == CW'(STACK_DEPTH);
  assign cnt_zero    = cnt_q == '0;
  assign cnt_one     = cnt_q == CW'(1);
  assign rd_match    = mem_rdata_i.key_pitch == ev_q.key_pitch;
  assign ev_on       = ev_q.velocity != '0;
  assign in_on       = in_item_i.velocity != '0;
  assign shift_more  = idx_inc < cnt_q;
  assign search_last = (idx_inc + CW'(1)) == cnt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_on) begin
            state_d = cnt_full ? ST_SHIFT : ST_PUSH;
          end else if (!cnt_zero) begin
            state_d = ST_TOP;
          end
        end
      end
      ST_PUSH:  state_d = ST_EMIT;
      ST_SHIFT: begin
        if (!shift_more) begin
          state_d = ev_on ? ST_PUSH : ST_IDLE;
        end
      end
      ST_TOP: begin
        if (rd_match) begin
          state_d = cnt_one ? ST_EMIT : ST_NEXT;
        end else begin
          state_d = cnt_one ? ST_EMIT : ST_SEARCH;
        end
      end
      ST_NEXT: state_d = ST_EMIT;
      ST_SEARCH: begin
        if (rd_match) begin
          state_d = ST_SHIFT;
        end else if (search_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    ev_d        = ev_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q - AW'(1);
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = idx_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ev_d = in_item_i;
          if (in_on) begin
            // full stack: drop the oldest by compacting from entry 1
            idx_d       = AW'(1);
            mem_raddr_o = AW'(1);
          end else begin
            mem_raddr_o = cnt_m1[AW-1:0];
          end
        end
      end
      ST_PUSH: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q[AW-1:0];
        mem_wdata_o = ev_q;
        cnt_d       = cnt_q + CW'(1);
        res_d       = out_item_t'(ev_q);
      end
      ST_SHIFT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q - AW'(1);
        mem_wdata_o = mem_rdata_i;
        mem_raddr_o = idx_inc[AW-1:0];
        if (shift_more) begin
          idx_d = idx_inc[AW-1:0];
        end else begin
          cnt_d = cnt_m1;
        end
      end
      ST_TOP: begin
        if (rd_match) begin
          cnt_d       = cnt_m1;
          mem_raddr_o = cnt_m2[AW-1:0];
          res_d       = '{out_chan: ev_q.chan, out_pitch: ev_q.key_pitch, out_velocity: '0};
        end else begin
          idx_d       = '0;
          mem_raddr_o = '0;
          res_d       = out_item_t'(ev_q);
        end
      end
      ST_NEXT: res_d = out_item_t'(mem_rdata_i);
      ST_SEARCH: begin
        mem_raddr_o = idx_inc[AW-1:0];
        if (!search_last || rd_match) begin
          idx_d = idx_inc[AW-1:0];
        end
        res_d = out_item_t'(ev_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    ev_q  <= ev_d;
    res_q <= res_d;
  end

  assign res_valid_o = state_q == ST_EMIT;
  assign res_o       = res_q;

endmodule

[rtl/core/last_note_priority_stack.sv]
// Top level of the monophonic last-note-priority voice tracker.
// One note event per item, velocity zero meaning note-off; each event gives zero or one
// result item. Held notes live in a STACK_DEPTH-entry memory with registered read data
// and are handled one event at a time by a read-modify-write sequencer. A note-on is
// pushed directly, or after the oldest note is compacted out when the stack is full.
// A note-off on an empty stack is dropped, one that hits the top pops it, and one that
// searches deeper entries either compacts out a match or passes the event through; the
// search and the compaction each move one memory entry per cycle. A result that finds
// the output register still full waits until it is taken. Results sit in an output
// register, so the next event is taken while a result waits. No clearing pass after
// reset: only entries below the held count are read.
module last_note_priority_stack #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lnps_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lnps_pkg::out_item_t out_item_o
);
  import lnps_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  in_item_t      mem_wdata, mem_rdata;
  logic          res_valid, res_ready;
  out_item_t     res;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q;

  lnps_mem #(.STACK_DEPTH(STACK_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lnps_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  assign res_ready   = !out_valid_q || out_ready_i;
  assign out_valid_d = (res_valid && res_ready) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[sim/tb_last_note_priority_stack.sv]
// Testbench for last_note_priority_stack: directed table and random note runs, predictor-checked.
module tb_last_note_priority_stack;
  import lnps_pkg::*;

  localparam int DEPTH      = 16;
  localparam int N_ITEMS    = 2000;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT = 2 * DEPTH + 20;
  localparam int NDIR       = 21;

  typedef struct {
    int c;
    int p;
    int v;
    bit typed;
    bit has;
    int rc;
    int rp;
    int rv;
  } dir_row_t;

  // note-off on empty, extremes, pop to re-sound, pop to stop, pass-through,
  // silent deeper removal, duplicate pitches, channel taken from the stored note
  dir_row_t dir_rows [NDIR] = '{
    '{0, 60, 0, 1, 0, 0, 0, 0},
    '{15, 127, 127, 1, 1, 15, 127, 127},
    '{0, 0, 1, 1, 1, 0, 0, 1},
    '{8, 0, 0, 1, 1, 15, 127, 127},
    '{5, 127, 0, 1, 1, 5, 127, 0},
    '{3, 60, 100, 1, 1, 3, 60, 100},
    '{7, 61, 0, 1, 1, 7, 61, 0},
    '{3, 62, 90, 1, 1, 3, 62, 90},
    '{9, 60, 0, 1, 0, 0, 0, 0},
    '{3, 62, 0, 1, 1, 3, 62, 0},
    '{1, 64, 10, 0, 0, 0, 0, 0},
    '{2, 64, 20, 0, 0, 0, 0, 0},
    '{4, 65, 30, 0, 0, 0, 0, 0},
    '{6, 64, 0, 0, 0, 0, 0, 0},
    '{6, 65, 0, 0, 0, 0, 0, 0},
    '{0, 64, 0, 0, 0, 0, 0, 0},
    '{10, 42, 85, 0, 0, 0, 0, 0},
    '{12, 85, 42, 0, 0, 0, 0, 0},
    '{11, 85, 0, 0, 0, 0, 0, 0},
    '{11, 42, 0, 0, 0, 0, 0, 0},
    '{15, 127, 0, 1, 0, 0, 0, 0}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  in_item_t  shadow_held [DEPTH];
  int        shadow_count = 0;
  out_item_t expected_voice_q [$];

  int  errors = 0;
  int  n_played = 0;
  int  n_ignored = 0;
  int  n_results = 0;
  int  n_on = 0;
  int  n_full = 0;
  int  n_resound = 0;
  int  n_stop = 0;
  int  n_silent = 0;
  int  n_pass = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  bit  drained_once = 1'b0;

  last_note_priority_stack #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic in_item_t mk_event(int c, int p, int v);
    in_item_t ev;
    ev.chan      = c[3:0];
    ev.key_pitch = p[6:0];
    ev.velocity  = v[6:0];
    return ev;
  endfunction

  function automatic out_item_t mk_voice(logic [3:0] c, logic [6:0] p, logic [6:0] v);
    out_item_t r;
    r.out_chan     = c;
    r.out_pitch    = p;
    r.out_velocity = v;
    return r;
  endfunction

  function automatic void drop_held(int pos);
    for (int i = pos; i < shadow_count - 1; i++) shadow_held[i] = shadow_held[i + 1];
    shadow_count--;
  endfunction

  function automatic void voice_predict(input in_item_t ev, output bit has,
                                        output out_item_t res);
    int hit;
    has = 1'b0;
    res = '0;
    hit = -1;
    if (ev.velocity != 7'd0) begin
      n_on++;
      if (shadow_count == DEPTH) begin
        n_full++;
        drop_held(0);
      end
      shadow_held[shadow_count] = ev;
      shadow_count++;
      has = 1'b1;
      res = mk_voice(ev.chan, ev.key_pitch, ev.velocity);
    end else if (shadow_count == 0) begin
      has = 1'b0;
    end else if (shadow_held[shadow_count - 1].key_pitch == ev.key_pitch) begin
      shadow_count--;
      has = 1'b1;
      if (shadow_count == 0) begin
        n_stop++;
        res = mk_voice(ev.chan, ev.key_pitch, 7'd0);
      end else begin
        n_resound++;
        res = mk_voice(shadow_held[shadow_count - 1].chan,
                       shadow_held[shadow_count - 1].key_pitch,
                       shadow_held[shadow_count - 1].velocity);
      end
    end else begin
      for (int i = 0; i < shadow_count; i++)
        if (hit < 0 && shadow_held[i].key_pitch == ev.key_pitch) hit = i;
      if (hit >= 0) begin
        n_silent++;
        drop_held(hit);
      end else begin
        n_pass++;
        has = 1'b1;
        res = mk_voice(ev.chan, ev.key_pitch, ev.velocity);
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 50) $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic play_event(input in_item_t ev, input bit typed, input bit t_has,
                            input out_item_t t_res);
    bit        has;
    out_item_t res;
    while (!no_idle && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= ev;
    do @(posedge clk_i); while (!in_ready);
    if (ev.velocity == 7'd0 && shadow_count == 0) n_ignored++;
    else n_played++;
    voice_predict(ev, has, res);
    if (typed) begin
      has = t_has;
      res = t_res;
    end
    if (has) expected_voice_q = {expected_voice_q, res};
  endtask

  task automatic play(input in_item_t ev);
    play_event(ev, 1'b0, 1'b0, '0);
  endtask

  function automatic in_item_t held_off(bit any_depth);
    int idx;
    if (shadow_count == 0) return mk_event($urandom_range(15), $urandom_range(127), 0);
    idx = any_depth ? $urandom_range(shadow_count - 1) : shadow_count - 1;
    return mk_event($urandom_range(15), int'(shadow_held[idx].key_pitch), 0);
  endfunction

  task automatic play_legato(int len, int base);
    repeat (len) begin
      if (shadow_count == 0 || $urandom_range(99) < 55)
        play(mk_event($urandom_range(15), base + $urandom_range(11), $urandom_range(127, 1)));
      else if ($urandom_range(99) < 85)
        play(held_off($urandom_range(1)));
      else
        play(mk_event($urandom_range(15), $urandom_range(127), 0));
    end
  endtask

  task automatic play_fill(int n, int base);
    repeat (n)
      play(mk_event($urandom_range(15), base + $urandom_range(11), $urandom_range(127, 1)));
    while (shadow_count > 0) play(held_off($urandom_range(2) != 0));
  endtask

  task automatic play_noise(int len);
    repeat (len)
      play(mk_event($urandom_range(15), $urandom_range(127),
                    $urandom_range(1) ? 0 : $urandom_range(127)));
  endtask

  always @(posedge clk_i) out_ready <= no_idle || ($urandom_range(99) >= 7);

  always @(posedge clk_i) begin
    out_item_t exp_v;
    if (rst_ni && out_valid && out_ready) begin
      n_results++;
      if (expected_voice_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result chan=%0d pitch=%0d vel=%0d",
                                  out_item.out_chan, out_item.out_pitch,
                                  out_item.out_velocity));
      end else begin
        exp_v = expected_voice_q.pop_front();
        if (out_item.out_chan !== exp_v.out_chan)
          report_mismatch($sformatf("out_chan got %0d exp %0d",
                                    out_item.out_chan, exp_v.out_chan));
        if (out_item.out_pitch !== exp_v.out_pitch)
          report_mismatch($sformatf("out_pitch got %0d exp %0d",
                                    out_item.out_pitch, exp_v.out_pitch));
        if (out_item.out_velocity !== exp_v.out_velocity)
          report_mismatch($sformatf("out_velocity got %0d exp %0d",
                                    out_item.out_velocity, exp_v.out_velocity));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb_last_note_priority_stack: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NDIR; r++)
      play_event(mk_event(dir_rows[r].c, dir_rows[r].p, dir_rows[r].v), dir_rows[r].typed,
                 dir_rows[r].has,
                 mk_voice(dir_rows[r].rc[3:0], dir_rows[r].rp[6:0], dir_rows[r].rv[6:0]));

    // overflow the stack first so the full-stack push is always hit
    play_fill(20, $urandom_range(116));
    while (n_played < N_ITEMS) begin
      no_idle = (n_played >= 700 && n_played < 1000);
      mode = $urandom_range(9);
      if (mode < 6) play_legato($urandom_range(60, 10), $urandom_range(116));
      else if (mode < 8) play_fill($urandom_range(24, 10), $urandom_range(116));
      else play_noise($urandom_range(20, 5));
      if ((n_played >= 1000 && !drained_once) || $urandom_range(15) == 0) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
        while (expected_voice_q.size() != 0) @(posedge clk_i);
        drained_once = 1'b1;
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_voice_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d note events (%0d ignored offs), %0d results checked",
             n_played, n_ignored, n_results);
    $display("note-ons %0d (full %0d), re-sounds %0d, stops %0d, silent %0d, pass %0d",
             n_on, n_full, n_resound, n_stop, n_silent, n_pass);
    if (errors == 0) begin
      $display("tb_last_note_priority_stack: PASS");
    end else begin
      $display("tb_last_note_priority_stack: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lnps_pkg.sv
rtl/core/lnps_mem.sv
rtl/core/lnps_ctrl.sv
rtl/core/last_note_priority_stack.sv
sim/tb_last_note_priority_stack.sv
